// File: hw/rtl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants for the stable matching engine.
// ----------------------------------------------------------------------------
package sme_pkg;

    // Width of every index and rank field on the ports.
    localparam int IDX_W = 4;
    // Width of the pair count register.
    localparam int NUM_W = 5;
    localparam int MAX_PAIRS_DEFAULT = 16;
    localparam logic [NUM_W-1:0] NUM_PAIRS_RESET = 5'd16;

    // Request opcodes. The unused opcode is accepted and ignored.
    localparam logic [1:0] OP_LOAD_PREF = 2'd0;
    localparam logic [1:0] OP_LOAD_RANK = 2'd1;
    localparam logic [1:0] OP_START     = 2'd2;
    localparam logic [1:0] OP_NONE      = 2'd3;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] person;
        logic [IDX_W-1:0] position;
        logic [IDX_W-1:0] other;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] acceptor_index;
        logic [IDX_W-1:0] partner_index;
        logic             has_partner;
        logic             last_result;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LIST,
        ST_RANK,
        ST_EMIT
    } state_t;

endpackage

// File: hw/rtl/sme_tables.sv
// ----------------------------------------------------------------------------
// sme_tables
// Preference list and rank memories, written by load requests, one
// registered read port each.
// ----------------------------------------------------------------------------
module sme_tables
    import sme_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  in_item_t                        wr_item,
    input  logic [2*$clog2(MAX_PAIRS)-1:0]  list_addr,
    input  logic [2*$clog2(MAX_PAIRS)-1:0]  rank_addr,
    output logic [IDX_W-1:0]                list_q,
    output logic [IDX_W-1:0]                rank_q
);

    localparam int PW    = $clog2(MAX_PAIRS);
    localparam int DEPTH = 2 ** (2 * PW);
    localparam int CMP_W = IDX_W + PW + 1;

    logic [IDX_W-1:0] list_mem [DEPTH];
    logic [IDX_W-1:0] rank_mem [DEPTH];

    logic person_ok;
    logic position_ok;
    logic other_ok;

    // Loads outside the configured table size are dropped.
    assign person_ok   = CMP_W'(wr_item.person)   < CMP_W'(MAX_PAIRS);
    assign position_ok = CMP_W'(wr_item.position) < CMP_W'(MAX_PAIRS);
    assign other_ok    = CMP_W'(wr_item.other)    < CMP_W'(MAX_PAIRS);

    // Proposer preference list: row is the proposer, column the position.
    always_ff @(posedge aclk) begin
        if (wr_en && wr_item.opcode == OP_LOAD_PREF && person_ok && position_ok) begin
            list_mem[{PW'(wr_item.person), PW'(wr_item.position)}] <= wr_item.other;
        end
        list_q <= list_mem[list_addr];
    end

    // Acceptor rank table: row is the acceptor, column the proposer.
    always_ff @(posedge aclk) begin
        if (wr_en && wr_item.opcode == OP_LOAD_RANK && person_ok && position_ok
                && other_ok) begin
            rank_mem[{PW'(wr_item.person), PW'(wr_item.other)}] <= wr_item.position;
        end
        rank_q <= rank_mem[rank_addr];
    end

endmodule

// File: hw/rtl/sme_core.sv
// ----------------------------------------------------------------------------
// sme_core
// Sequencer for deferred acceptance: walks proposers one offer at a time
// through a single rank compare, then streams out one result per acceptor.
// ----------------------------------------------------------------------------
module sme_core
    import sme_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [$clog2(MAX_PAIRS+1)-1:0]  n_eff,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  in_item_t                        s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output out_item_t                       m_data,
    output logic [2*$clog2(MAX_PAIRS)-1:0]  list_addr,
    output logic [2*$clog2(MAX_PAIRS)-1:0]  rank_addr,
    input  logic [IDX_W-1:0]                list_q,
    input  logic [IDX_W-1:0]                rank_q
);

    localparam int PW    = $clog2(MAX_PAIRS);
    localparam int CW    = $clog2(MAX_PAIRS + 1);
    localparam int CMP_W = IDX_W + CW;

    state_t state_reg, state_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] e_reg, e_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic          offered_reg, offered_next;
    logic [MAX_PAIRS-1:0] snap_reg, snap_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_data_reg, m_data_next;

    // Per-proposer and per-acceptor matching state.
    logic [CW-1:0]    nc_reg    [MAX_PAIRS];
    logic [MAX_PAIRS-1:0] matched_reg;
    logic [MAX_PAIRS-1:0] matched_upd;
    logic [MAX_PAIRS-1:0] holds_reg;
    logic [PW-1:0]    held_reg  [MAX_PAIRS];
    logic [IDX_W-1:0] hrank_reg [MAX_PAIRS];

    logic [PW-1:0] p_idx;
    logic [PW-1:0] e_idx;
    logic [PW-1:0] a_idx;
    logic          clear_all;
    logic          nc_inc;
    logic          win;

    assign p_idx = p_reg[PW-1:0];
    assign e_idx = e_reg[PW-1:0];
    assign a_idx = PW'(list_q);

    assign list_addr = {p_idx, nc_reg[p_idx][PW-1:0]};
    assign rank_addr = {a_idx, p_idx};

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            p_reg       <= '0;
            e_reg       <= '0;
            offered_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p_reg       <= p_next;
            e_reg       <= e_next;
            offered_reg <= offered_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        snap_reg   <= snap_next;
        m_data_reg <= m_data_next;
    end

    // Matched flags after a winning offer: the displaced proposer is freed.
    always_comb begin
        matched_upd = matched_reg;
        if (holds_reg[acc_reg]) begin
            matched_upd[held_reg[acc_reg]] = 1'b0;
        end
        matched_upd[p_idx] = 1'b1;
    end

    // Matching state: cleared at reset and at the start of every run.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_all) begin
            matched_reg <= '0;
            holds_reg   <= '0;
            for (int i = 0; i < MAX_PAIRS; i++) begin
                nc_reg[i]    <= '0;
                held_reg[i]  <= '0;
                hrank_reg[i] <= '0;
            end
        end else begin
            if (nc_inc) begin
                nc_reg[p_idx] <= nc_reg[p_idx] + CW'(1);
            end
            if (win) begin
                matched_reg        <= matched_upd;
                holds_reg[acc_reg] <= 1'b1;
                held_reg[acc_reg]  <= p_idx;
                hrank_reg[acc_reg] <= rank_q;
            end
        end
    end

    // Next state and outputs.
    always_comb begin
        state_next   = state_reg;
        p_next       = p_reg;
        e_next       = e_reg;
        acc_next     = acc_reg;
        offered_next = offered_reg;
        snap_next    = snap_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        clear_all    = 1'b0;
        nc_inc       = 1'b0;
        win          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_data.opcode == OP_START) begin
                    clear_all    = 1'b1;
                    p_next       = n_eff;
                    offered_next = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (p_reg == n_eff) begin
                    // End of a round: start another only if someone offered.
                    if (offered_reg) begin
                        snap_next    = ~matched_reg;
                        p_next       = '0;
                        offered_next = 1'b0;
                    end else begin
                        e_next     = '0;
                        state_next = ST_EMIT;
                    end
                end else if (snap_reg[p_idx] && nc_reg[p_idx] < n_eff) begin
                    nc_inc       = 1'b1;
                    offered_next = 1'b1;
                    state_next   = ST_LIST;
                end else begin
                    p_next = p_reg + CW'(1);
                end
            end
            ST_LIST: begin
                // An offer to an acceptor outside the range is used up.
                if (CMP_W'(list_q) < CMP_W'(n_eff)) begin
                    acc_next   = a_idx;
                    state_next = ST_RANK;
                end else begin
                    p_next     = p_reg + CW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_RANK: begin
                // The held proposer keeps its place on equal rank.
                win        = !holds_reg[acc_reg] || rank_q < hrank_reg[acc_reg];
                p_next     = p_reg + CW'(1);
                state_next = ST_SCAN;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.acceptor_index  = IDX_W'(e_reg);
                    m_data_next.has_partner     = holds_reg[e_idx];
                    m_data_next.partner_index   = holds_reg[e_idx] ?
                                                  IDX_W'(held_reg[e_idx]) : '0;
                    m_data_next.last_result     = (e_reg + CW'(1) == n_eff);
                    e_next                      = e_reg + CW'(1);
                    if (e_reg + CW'(1) == n_eff) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Matched proposers and holding acceptors are equal in number.
    a_match_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(holds_reg) == $countones(matched_reg))
        else $error("matched count differs from held count");

    // The proposer scan never runs past the pair count.
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> p_reg <= n_eff)
        else $error("proposer scan out of range");

    // A rank compare only happens for an acceptor in use.
    a_rank_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RANK |-> CW'(acc_reg) < n_eff)
        else $error("rank compare for acceptor out of range");

    // The last result names the last acceptor in use.
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.last_result |->
            m_data_reg.acceptor_index == IDX_W'(n_eff - CW'(1)))
        else $error("last flag on wrong acceptor");

endmodule

// File: hw/rtl/stable_matching_engine.sv
// ----------------------------------------------------------------------------
// stable_matching_engine
// Stable matching by deferred acceptance over loaded preference tables.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_valid/s_ready/s_data. A load preference or load rank
//   request writes one table entry; it gives no result.
//   A start request runs the matching over the first num_pairs proposers and
//   acceptors, then returns one result per acceptor on m_valid/m_ready/m_data,
//   in acceptor order, the final one flagged by last_result.
//   num_pairs is written on cfg_valid/cfg_ready/cfg_data while the block is
//   idle; 0 acts as 1 and values above MAX_PAIRS act as MAX_PAIRS.
// Timing:
//   Each offer passes the scan, list read, and rank read and compare steps, or
//   stops after the list read when the listed acceptor is out of use; each
//   skipped proposer and each round end take a scan step. With at most N*N
//   offers there are at most about N*N rounds, and the N results follow the
//   run. The single rank compare and the two registered table reads pace it.
//   s_ready is low from a start until the last result is loaded.
// Reset:
//   aresetn clears the sequencer and matching state and sets num_pairs to 16.
//   Table contents are kept and are only meaningful once loaded.
// Stalls:
//   The result register holds while m_ready is low and the sequencer waits.
// ----------------------------------------------------------------------------
module stable_matching_engine
    import sme_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [NUM_W-1:0] cfg_data
);

    localparam int PW    = $clog2(MAX_PAIRS);
    localparam int CW    = $clog2(MAX_PAIRS + 1);
    localparam int CMP_W = NUM_W + CW;

    logic [NUM_W-1:0] num_pairs_reg;
    logic [CW-1:0]    n_eff;
    logic [2*PW-1:0]  list_addr;
    logic [2*PW-1:0]  rank_addr;
    logic [IDX_W-1:0] list_q;
    logic [IDX_W-1:0] rank_q;

    assign cfg_ready = 1'b1;

    // Pair count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_pairs_reg <= NUM_PAIRS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            num_pairs_reg <= cfg_data;
        end
    end

    // Clamp the pair count into the supported range.
    always_comb begin
        if (num_pairs_reg == '0) begin
            n_eff = CW'(1);
        end else if (CMP_W'(num_pairs_reg) > CMP_W'(MAX_PAIRS)) begin
            n_eff = CW'(MAX_PAIRS);
        end else begin
            n_eff = CW'(num_pairs_reg);
        end
    end

    sme_tables #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_tables (
        .aclk      (aclk),
        .wr_en     (s_valid && s_ready),
        .wr_item   (s_data),
        .list_addr (list_addr),
        .rank_addr (rank_addr),
        .list_q    (list_q),
        .rank_q    (rank_q)
    );

    sme_core #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .n_eff     (n_eff),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .list_addr (list_addr),
        .rank_addr (rank_addr),
        .list_q    (list_q),
        .rank_q    (rank_q)
    );

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stable matching engine: table loads, matching
// runs over several pair counts, and per-acceptor results against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import sme_pkg::*;

    // One directed row: the request and, for a start, an optional typed result.
    typedef struct packed {
        in_item_t  req;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [NUM_W-1:0] cfg_data = '0;

    // Predictor state and configuration.
    logic [IDX_W-1:0] pref_tbl [16][16];
    logic [IDX_W-1:0] rank_tbl [16][16];
    logic [NUM_W-1:0] pair_cfg;
    out_item_t        exp_mem [64];
    int               exp_wr = 0;
    int               exp_rd = 0;
    bit               typed_pending = 1'b0;
    out_item_t        typed_want;

    int n_fail = 0;
    int n_results = 0;
    int n_requests = 0;
    int n_starts = 0;
    bit quiet_rx = 1'b0;

    int cfg_list [7] = '{2, 3, 5, 0, 8, 4, 6};

    // Directed table: opcode extremes, ignored opcode, start after tiny tables.
    dir_row_t directed [13] = '{
        {OP_LOAD_PREF, 4'd0, 4'd0, 4'd0, 1'b0, 10'd0},
        {OP_LOAD_RANK, 4'd0, 4'd0, 4'd0, 1'b0, 10'd0},
        {OP_NONE, 4'd15, 4'd15, 4'd15, 1'b0, 10'd0},
        {OP_START, 4'd15, 4'd15, 4'd15, 1'b1, 4'd0, 4'd0, 1'b1, 1'b1},
        {OP_LOAD_PREF, 4'd1, 4'd0, 4'd1, 1'b0, 10'd0},
        {OP_LOAD_PREF, 4'd1, 4'd1, 4'd0, 1'b0, 10'd0},
        {OP_LOAD_PREF, 4'd0, 4'd1, 4'd1, 1'b0, 10'd0},
        {OP_LOAD_RANK, 4'd0, 4'd1, 4'd1, 1'b0, 10'd0},
        {OP_LOAD_RANK, 4'd1, 4'd0, 4'd0, 1'b0, 10'd0},
        {OP_LOAD_RANK, 4'd1, 4'd1, 4'd1, 1'b0, 10'd0},
        {OP_LOAD_PREF, 4'd15, 4'd15, 4'd15, 1'b0, 10'd0},
        {OP_LOAD_RANK, 4'd15, 4'd15, 4'd15, 1'b0, 10'd0},
        {OP_START, 4'd0, 4'd0, 4'd0, 1'b0, 10'd0}
    };

    stable_matching_engine i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Limit: far above the slowest correct run.
    initial begin
        #40000000;
        $display("stable_matching_engine test failed");
        $finish;
    end

    // Mostly short gaps, occasionally long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Add one expected result to the scoreboard ring.
    task automatic queue_result(input out_item_t r);
        exp_mem[exp_wr & 63] = r;
        exp_wr++;
    endtask

    // Run deferred acceptance on the predictor tables, queue expected results.
    task automatic predict_matching();
        int n, p, a, r, best, best_rank;
        bit found;
        bit offered;
        int nxt [16];
        bit matched [16];
        int held [16];
        bit holds [16];
        int target [16];
        out_item_t res;
        n = (pair_cfg == 0) ? 1 : ((pair_cfg > 16) ? 16 : int'(pair_cfg));
        for (p = 0; p < 16; p++) begin
            nxt[p] = 0; matched[p] = 0; held[p] = 0; holds[p] = 0;
        end
        do begin
            offered = 0;
            for (p = 0; p < n; p++) begin
                target[p] = -1;
                if (!matched[p] && nxt[p] < n) begin
                    a = pref_tbl[p][nxt[p]];
                    nxt[p]++;
                    offered = 1;
                    if (a < n) target[p] = a;
                end
            end
            for (a = 0; a < n; a++) begin
                found = holds[a];
                best = held[a];
                best_rank = holds[a] ? rank_tbl[a][held[a]] : 0;
                for (p = 0; p < n; p++) begin
                    if (target[p] == a) begin
                        r = rank_tbl[a][p];
                        if (!found || r < best_rank) begin
                            found = 1; best = p; best_rank = r;
                        end
                        matched[p] = 0;
                    end
                end
                if (found) begin
                    if (holds[a]) matched[held[a]] = 0;
                    held[a] = best; holds[a] = 1; matched[best] = 1;
                end
            end
        end while (offered);
        for (a = 0; a < n; a++) begin
            res.acceptor_index = a[IDX_W-1:0];
            res.partner_index  = holds[a] ? held[a][IDX_W-1:0] : '0;
            res.has_partner    = holds[a];
            res.last_result    = (a == n - 1);
            queue_result(res);
        end
    endtask

    // Apply one accepted request to the predictor.
    task automatic model_request(input in_item_t it);
        case (it.opcode)
            OP_LOAD_PREF: begin
                pref_tbl[it.person][it.position] = it.other;
            end
            OP_LOAD_RANK: begin
                rank_tbl[it.person][it.other] = it.position;
            end
            OP_START: begin
                if (typed_pending) queue_result(typed_want);
                else predict_matching();
                n_starts++;
            end
            default: begin
            end
        endcase
    endtask

    // Send one request; the predictor is updated at acceptance. Valid stays
    // high into the next request when there is no gap.
    task automatic send_request(input in_item_t it);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        model_request(it);
        n_requests++;
        @(negedge aclk);
    endtask

    // Send one row of the directed table.
    task automatic send_directed(input int idx);
        typed_pending = directed[idx].typed;
        typed_want    = directed[idx].want;
        send_request(directed[idx].req);
        typed_pending = 1'b0;
    endtask

    task automatic write_pairs(input logic [NUM_W-1:0] v);
        s_valid <= 1'b0;
        @(negedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        pair_cfg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (exp_wr != exp_rd) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // Load full tables for the first n people: random permutations.
    task automatic load_tables(input int n);
        int perm [16];
        int i, j, k, t;
        in_item_t it;
        for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) perm[j] = j;
            for (j = n - 1; j > 0; j--) begin
                k = $urandom_range(0, j);
                t = perm[j]; perm[j] = perm[k]; perm[k] = t;
            end
            for (j = 0; j < n; j++) begin
                it.opcode = OP_LOAD_PREF; it.person = 4'(i); it.position = 4'(j);
                // Occasionally list an acceptor that is out of use.
                it.other = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'(perm[j]);
                send_request(it);
            end
            for (j = 0; j < n; j++) perm[j] = j;
            for (j = n - 1; j > 0; j--) begin
                k = $urandom_range(0, j);
                t = perm[j]; perm[j] = perm[k]; perm[k] = t;
            end
            for (j = 0; j < n; j++) begin
                it.opcode = OP_LOAD_RANK; it.person = 4'(i); it.other = 4'(j);
                // Occasionally a tied rank.
                it.position = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'(perm[j]);
                send_request(it);
            end
        end
    endtask

    // Sixteen proposers with distinct first choices: one round settles it, so
    // only the first list position and the offered ranks are ever read.
    task automatic load_first_choices();
        int perm [16];
        int j, k, t;
        in_item_t it;
        for (j = 0; j < 16; j++) perm[j] = j;
        for (j = 15; j > 0; j--) begin
            k = $urandom_range(0, j);
            t = perm[j]; perm[j] = perm[k]; perm[k] = t;
        end
        for (j = 0; j < 16; j++) begin
            it.opcode = OP_LOAD_PREF; it.person = 4'(j); it.position = 4'd0;
            it.other = 4'(perm[j]);
            send_request(it);
            it.opcode = OP_LOAD_RANK; it.person = 4'(perm[j]); it.other = 4'(j);
            it.position = 4'($urandom_range(0, 15));
            send_request(it);
        end
    endtask

    // Result receiver with random stalls.
    initial begin
        out_item_t want;
        int g;
        forever begin
            @(negedge aclk);
            if (quiet_rx) begin
                m_ready <= 1'b1;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    m_ready <= 1'b0;
                    repeat (g) @(negedge aclk);
                end
                m_ready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_valid && m_ready));
            n_results++;
            if (exp_wr == exp_rd) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result %p", m_data);
            end else begin
                want = exp_mem[exp_rd & 63];
                exp_rd++;
                if (m_data.acceptor_index !== want.acceptor_index ||
                    m_data.partner_index !== want.partner_index ||
                    m_data.has_partner !== want.has_partner ||
                    m_data.last_result !== want.last_result) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: expected %p got %p", want, m_data);
                end
            end
        end
    end

    initial begin
        int i, ph, n;
        in_item_t it;
        for (i = 0; i < 16; i++)
            for (n = 0; n < 16; n++) begin
                pref_tbl[i][n] = '0; rank_tbl[i][n] = '0;
            end
        pair_cfg = NUM_PAIRS_RESET;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Single pair: one acceptor, matched to proposer zero.
        write_pairs(5'd1);
        for (i = 0; i < 4; i++) send_directed(i);
        wait_drained();
        // Two pairs, then the rest of the table including index extremes.
        write_pairs(5'd2);
        for (i = 4; i < 13; i++) send_directed(i);
        wait_drained();

        // Pair count above the supported range, then the full count itself.
        write_pairs(5'd31);
        load_first_choices();
        it = '{OP_START, 4'd0, 4'd0, 4'd0};
        send_request(it);
        wait_drained();
        write_pairs(NUM_PAIRS_RESET);
        send_request(it);
        wait_drained();

        // Random phases over several pair counts.
        foreach (cfg_list[ph]) begin
            n = (cfg_list[ph] == 0) ? 1 : ((cfg_list[ph] > 16) ? 16 : cfg_list[ph]);
            write_pairs(NUM_W'(cfg_list[ph]));
            load_tables(n);
            for (i = 0; i < 3; i++) begin
                it.opcode = OP_START;
                it.person = 4'($urandom); it.position = 4'($urandom);
                it.other = 4'($urandom);
                send_request(it);
                // Reshuffle a few entries between runs; some noise requests.
                repeat (4) begin
                    it.opcode = 2'($urandom_range(0, 3));
                    if (it.opcode == OP_START) it.opcode = OP_LOAD_RANK;
                    it.person = 4'($urandom_range(0, n - 1));
                    it.position = 4'($urandom);
                    it.other = 4'($urandom_range(0, n - 1));
                    send_request(it);
                end
            end
            // Sender holds off until every expected result has come.
            wait_drained();
            quiet_rx = (ph == 4);
        end
        quiet_rx = 0;

        wait_drained();
        repeat (100) @(negedge aclk);
        $display("covered %0d requests, %0d matching runs, %0d results checked",
                 n_requests, n_starts, n_results);
        if (n_fail == 0 && exp_wr == exp_rd) begin
            $display("stable_matching_engine test passed");
        end else begin
            $display("%0d mismatches, %0d results outstanding", n_fail, exp_wr - exp_rd);
            $display("stable_matching_engine test failed");
        end
        $finish;
    end

endmodule
